// ===== sv/rpra_pkg.sv =====
// Package: types and constants for the rarefied private richness accumulator
package rpra_pkg;
    localparam int FracBits  = 16;
    localparam int CntW      = 11;
    localparam int PoolW     = 13;
    localparam int QW        = FracBits + 1;
    localparam int LocusW    = FracBits + 16;
    localparam int SumW      = 40;
    localparam int NumW      = 41;
    localparam int LociW     = 24;
    localparam logic [QW-1:0] FxOne = QW'(1) << FracBits;

    typedef struct packed {
        logic [CntW-1:0] total_pop_one;
        logic [CntW-1:0] total_pop_two;
        logic [CntW-1:0] total_pop_three;
        logic [CntW-1:0] allele_pop_one;
        logic [CntW-1:0] allele_pop_two;
        logic [CntW-1:0] allele_pop_three;
        logic            last_allele;
        logic            last_in_block;
    } t_in_item;

    typedef struct packed {
        logic [SumW-1:0] pi13_sum;
        logic [SumW-1:0] pi23_sum;
        logic [NumW-1:0] numerator_sum;
        logic [SumW-1:0] denominator_sum;
        logic [LociW-1:0] loci_counted;
    } t_out_item;

    typedef enum logic [3:0] {
        S_IDLE, S_LATCH, S_QSETUP, S_QMUL, S_QDIV, S_QNEXT,
        S_MUL1, S_MUL2, S_MUL3, S_MUL4, S_LOCUS, S_EMIT
    } t_state;
endpackage

// ===== sv/rpra_if.sv =====
// Interfaces: valid/ready channels for input and result items
interface rpra_in_if (input logic i_clk);
    import rpra_pkg::*;
    logic     valid;
    logic     ready;
    t_in_item data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface rpra_out_if (input logic i_clk);
    import rpra_pkg::*;
    logic      valid;
    logic      ready;
    t_out_item data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== sv/rarefied_private_richness_accumulator.sv =====
// Top level: rarefied private richness accumulator with shared iterative divider
//
//  channel     | dir | handshake      | payload
//  in_ch       | in  | valid/ready    | totals, allele counts, last flags
//  out_ch      | out | valid/ready    | block sums and loci count
//  cfg         | in  | i_cfg_we       | sample_size (11 bits)
//
// Per item, the four Q values are computed in turn by the one restoring
// divider (one quotient bit a cycle), then come the fraction products and
// locus bookkeeping. A skipped locus item bypasses the Q values and products.
// Reset (synchronous, active low) clears control and the sums; g is released.
// The result sits in an output register; the next item is taken while it
// waits, but a further block end stalls until the register is emptied.
module rarefied_private_richness_accumulator (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [rpra_pkg::CntW-1:0] i_cfg_data,
    rpra_in_if.sink               in_ch,
    rpra_out_if.source            out_ch
);
    import rpra_pkg::*;

    localparam int DivW = FracBits + 1 + PoolW;  // dividend width q*(rest)
    localparam int DivCntW = $clog2(DivW + 1);

    t_state r_state, n_state;

    logic [CntW-1:0]  r_sample_size;
    logic [CntW-1:0]  r_draw;
    logic             r_draw_fixed;
    logic             r_skip;
    logic             r_locus_start;
    t_in_item         r_item;
    logic [LocusW-1:0] r_l13, r_l23, r_lalpha;
    logic [SumW-1:0]  r_b13, r_b23, r_bden;
    logic [NumW-1:0]  r_bnum;
    logic [LociW-1:0] r_bloci;
    logic             r_ovalid;
    t_out_item        r_odata;

    // shared Q iterator
    logic [1:0]       r_qsel;
    logic [QW-1:0]    r_q;
    logic [QW-1:0]    r_qv [4];
    logic [CntW-1:0]  r_i;
    logic [PoolW-1:0] r_rest, r_tot;
    logic [DivW-1:0]  r_dvd;
    logic [PoolW:0]   r_rem;
    logic [DivCntW-1:0] r_dcnt;
    logic [2*QW-1:0]  r_prod;
    logic [QW-1:0]    r_t13, r_t23;

    logic [PoolW-1:0] w_tot, w_cnt;
    logic [CntW-1:0]  w_min;
    logic             w_accept;
    logic [PoolW:0]   w_trial;

    assign w_accept = in_ch.valid && in_ch.ready;
    assign in_ch.ready = (r_state == S_IDLE);
    assign out_ch.valid = r_ovalid;
    assign out_ch.data  = r_odata;

    always_comb begin
        w_min = r_item.total_pop_one;
        if (r_item.total_pop_two < w_min) w_min = r_item.total_pop_two;
        if (r_item.total_pop_three < w_min) w_min = r_item.total_pop_three;
    end

    // select totals and counts for the Q under work
    always_comb begin
        case (r_qsel)
            2'd0: begin
                w_tot = PoolW'(r_item.total_pop_one);
                w_cnt = PoolW'(r_item.allele_pop_one);
            end
            2'd1: begin
                w_tot = PoolW'(r_item.total_pop_two);
                w_cnt = PoolW'(r_item.allele_pop_two);
            end
            2'd2: begin
                w_tot = PoolW'(r_item.total_pop_three);
                w_cnt = PoolW'(r_item.allele_pop_three);
            end
            default: begin
                w_tot = PoolW'(r_item.total_pop_one) + PoolW'(r_item.total_pop_two)
                      + PoolW'(r_item.total_pop_three);
                w_cnt = PoolW'(r_item.allele_pop_one) + PoolW'(r_item.allele_pop_two)
                      + PoolW'(r_item.allele_pop_three);
            end
        endcase
    end

    assign w_trial = {r_rem[PoolW-1:0], r_dvd[DivW-1]} - {1'b0, r_tot};

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:   if (w_accept) n_state = S_LATCH;
            S_LATCH:  n_state = S_QSETUP;
            S_QSETUP: begin
                if (r_skip) n_state = S_LOCUS;
                else if (w_cnt > w_tot || (w_tot - w_cnt) < PoolW'(r_draw)
                         || r_draw == '0) n_state = S_QNEXT;
                else n_state = S_QMUL;
            end
            S_QMUL:   n_state = S_QDIV;
            S_QDIV:   if (r_dcnt == DivCntW'(1)) begin
                n_state = (r_i + 1'b1 == r_draw) ? S_QNEXT : S_QMUL;
            end
            S_QNEXT:  n_state = (r_qsel == 2'd3) ? S_MUL1 : S_QSETUP;
            S_MUL1:   n_state = S_MUL2;
            S_MUL2:   n_state = S_MUL3;
            S_MUL3:   n_state = S_MUL4;
            S_MUL4:   n_state = S_LOCUS;
            S_LOCUS:  n_state = r_item.last_in_block ? S_EMIT : S_IDLE;
            S_EMIT:   n_state = (!r_ovalid || out_ch.ready) ? S_IDLE : S_EMIT;
            default:  n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_IDLE;
        else          r_state <= n_state;
    end

    // datapath and outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sample_size <= '0;
            r_draw        <= '0;
            r_draw_fixed  <= 1'b0;
            r_skip        <= 1'b0;
            r_locus_start <= 1'b1;
            r_l13 <= '0; r_l23 <= '0; r_lalpha <= '0;
            r_b13 <= '0; r_b23 <= '0; r_bden <= '0; r_bnum <= '0; r_bloci <= '0;
            r_ovalid <= 1'b0;
            r_qsel <= '0;
        end else begin
            if (i_cfg_we) r_sample_size <= i_cfg_data;
            // drop the result once taken, unless a new one is loaded in its place
            if (r_ovalid && out_ch.ready && r_state != S_EMIT) r_ovalid <= 1'b0;
            unique case (r_state)
                S_IDLE: if (w_accept) r_item <= in_ch.data;
                S_LATCH: begin
                    r_qsel <= 2'd0;
                    if (r_locus_start) begin
                        r_locus_start <= 1'b0;
                        if (!r_draw_fixed) begin
                            r_draw_fixed <= 1'b1;
                            r_draw <= (r_sample_size != '0) ? r_sample_size : w_min;
                            r_skip <= (r_sample_size != '0) && (r_sample_size > w_min);
                        end else begin
                            r_skip <= r_draw > w_min;
                        end
                    end
                end
                S_QSETUP: begin
                    r_i    <= '0;
                    r_tot  <= w_tot;
                    r_rest <= w_tot - w_cnt;
                    if (w_cnt > w_tot || (w_tot - w_cnt) < PoolW'(r_draw)) r_q <= '0;
                    else r_q <= FxOne;
                end
                S_QMUL: begin
                    // dividend q*(rest-i), then restoring divide by tot-i
                    r_dvd  <= DivW'(r_q * (r_rest - PoolW'(r_i)));
                    r_tot  <= r_tot;
                    r_rem  <= '0;
                    r_dcnt <= DivCntW'(DivW);
                end
                S_QDIV: begin
                    if (!w_trial[PoolW]) begin
                        r_rem <= w_trial;
                        r_dvd <= {r_dvd[DivW-2:0], 1'b1};
                    end else begin
                        r_rem <= {r_rem[PoolW-1:0], r_dvd[DivW-1]};
                        r_dvd <= {r_dvd[DivW-2:0], 1'b0};
                    end
                    r_dcnt <= r_dcnt - 1'b1;
                    if (r_dcnt == DivCntW'(1)) begin
                        r_q <= (!w_trial[PoolW]) ? QW'({r_dvd[DivW-2:0], 1'b1})
                                                 : QW'({r_dvd[DivW-2:0], 1'b0});
                        r_i <= r_i + 1'b1;
                        r_tot <= r_tot - 1'b1;
                    end
                end
                S_QNEXT: begin
                    r_qv[r_qsel] <= r_q;
                    r_qsel <= r_qsel + 1'b1;
                end
                S_MUL1: r_prod <= (FxOne - r_qv[0]) * (FxOne - r_qv[2]);
                S_MUL2: begin
                    r_t13  <= QW'(r_prod >> FracBits);
                    r_prod <= (FxOne - r_qv[1]) * (FxOne - r_qv[2]);
                end
                S_MUL3: begin
                    r_t23  <= QW'(r_prod >> FracBits);
                    r_prod <= r_t13 * r_qv[1];
                end
                S_MUL4: begin
                    r_l13 <= r_l13 + LocusW'(r_prod >> FracBits);
                    r_prod <= r_t23 * r_qv[0];
                    r_lalpha <= r_lalpha + LocusW'(FxOne - r_qv[3]);
                end
                S_LOCUS: begin
                    logic [LocusW-1:0] v13, v23, va;
                    v13 = r_l13;
                    v23 = r_l23;
                    va  = r_lalpha;
                    if (!r_skip) v23 = r_l23 + LocusW'(r_prod >> FracBits);
                    if (r_item.last_allele || r_item.last_in_block) begin
                        if (!r_skip && (v13 != '0 || v23 != '0)) begin
                            r_b13 <= r_b13 + SumW'(v13);
                            r_b23 <= r_b23 + SumW'(v23);
                            r_bnum <= r_bnum + NumW'(v23) - NumW'(v13);
                            r_bden <= r_bden + SumW'(va);
                            r_bloci <= r_bloci + 1'b1;
                        end
                        r_l13 <= '0; r_l23 <= '0; r_lalpha <= '0;
                        r_skip <= 1'b0;
                        r_locus_start <= 1'b1;
                    end else begin
                        r_l23 <= v23;
                    end
                end
                S_EMIT: if (!r_ovalid || out_ch.ready) begin
                    r_ovalid <= 1'b1;
                    r_odata.pi13_sum        <= r_b13;
                    r_odata.pi23_sum        <= r_b23;
                    r_odata.numerator_sum   <= r_bnum;
                    r_odata.denominator_sum <= r_bden;
                    r_odata.loci_counted    <= r_bloci;
                    r_b13 <= '0; r_b23 <= '0; r_bnum <= '0; r_bden <= '0;
                    r_bloci <= '0;
                    r_draw <= '0;
                    r_draw_fixed <= 1'b0;
                end
                default: ;
            endcase
        end
    end

    a_ready_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_ch.ready |-> r_state == S_IDLE) else $error("ready outside idle");
    a_q_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_QNEXT |-> r_q <= FxOne) else $error("Q above one");
    a_emit_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_EMIT |-> r_item.last_in_block) else $error("emit without block end");
endmodule
